>>> sv/crs_pkg.sv
// Shared types, constants and the micro-program of the chromatography residual stencil.
`default_nettype none
package crs_pkg;

  localparam int unsigned MAX_POINTS_DEF = 1024;
  localparam int unsigned QUEUE_DEPTH    = 2;
  localparam int unsigned PC_W           = 6;
  localparam int unsigned DATA_W         = 36;
  localparam int unsigned TEMP_DEPTH     = 8;

  localparam logic [2:0] REG_VELOCITY   = 3'd0;
  localparam logic [2:0] REG_DISPERSION = 3'd1;
  localparam logic [2:0] REG_POROSITY   = 3'd2;
  localparam logic [2:0] REG_CAPACITY   = 3'd3;
  localparam logic [2:0] REG_AFFINITY   = 3'd4;
  localparam logic [2:0] REG_TIME_STEP  = 3'd5;
  localparam logic [2:0] REG_FEED_LEVEL = 3'd6;

  localparam logic signed [31:0] FX_MAX = 32'sh7fffffff;
  localparam logic signed [31:0] FX_MIN = 32'sh80000000;

  typedef logic signed [DATA_W-1:0] dat_t;

  typedef struct packed {
    logic signed [31:0] velocity;
    logic [30:0]        dispersion;
    logic [15:0]        porosity;
    logic [30:0]        capacity;
    logic [30:0]        affinity;
    logic [30:0]        time_step;
    logic signed [31:0] feed_level;
  } cfg_t;

  typedef enum logic [1:0] {
    K_SINGLE,
    K_INLET,
    K_INTERIOR
  } kind_e;

  typedef struct packed {
    kind_e              kind;
    logic               end_flag;
    logic [9:0]         cnt;
    logic signed [31:0] older_prev;
    logic signed [31:0] older_trial;
    logic signed [31:0] recent_prev;
    logic signed [31:0] recent_trial;
    logic [30:0]        recent_spacing;
    logic signed [31:0] cur_prev;
    logic signed [31:0] cur_trial;
    logic [30:0]        cur_spacing;
  } job_t;

  typedef enum logic [2:0] {
    OP_ADD,
    OP_SUB,
    OP_ADDS,
    OP_SUBS,
    OP_HALF,
    OP_MUL,
    OP_DIV,
    OP_END
  } op_e;

  typedef enum logic [4:0] {
    S_ZERO  = 5'd0,
    S_ONE   = 5'd1,
    S_EPS   = 5'd2,
    S_VEL   = 5'd3,
    S_DISP  = 5'd4,
    S_POR   = 5'd5,
    S_CAP   = 5'd6,
    S_AFF   = 5'd7,
    S_TSTEP = 5'd8,
    S_FEED  = 5'd9,
    S_OP    = 5'd10,
    S_OT    = 5'd11,
    S_RP    = 5'd12,
    S_RT    = 5'd13,
    S_RH    = 5'd14,
    S_CP    = 5'd15,
    S_CT    = 5'd16,
    S_H     = 5'd17,
    S_T0    = 5'd24,
    S_T1    = 5'd25,
    S_T2    = 5'd26,
    S_T3    = 5'd27,
    S_T4    = 5'd28,
    S_T5    = 5'd29,
    S_T6    = 5'd30,
    S_T7    = 5'd31
  } src_e;

  typedef struct packed {
    op_e  op;
    src_e dst;
    src_e a;
    src_e b;
  } uop_t;

  localparam logic [PC_W-1:0] P_INTERIOR = 6'd0;
  localparam logic [PC_W-1:0] P_INLET    = 6'd44;
  localparam logic [PC_W-1:0] P_LAST     = 6'd54;
  localparam logic [PC_W-1:0] P_SINGLE   = 6'd61;

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    logic signed [31:0] r;
    if (v > 64'sd2147483647) begin
      r = FX_MAX;
    end else if (v < -64'sd2147483648) begin
      r = FX_MIN;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  function automatic uop_t mk(input op_e op, input src_e dst, input src_e a, input src_e b);
    uop_t u;
    u.op  = op;
    u.dst = dst;
    u.a   = a;
    u.b   = b;
    return u;
  endfunction

  function automatic logic [PC_W-1:0] entry_pc(input kind_e kind);
    logic [PC_W-1:0] p;
    case (kind)
      K_SINGLE: p = P_SINGLE;
      K_INLET:  p = P_INLET;
      default:  p = P_INTERIOR;
    endcase
    return p;
  endfunction

  // Each step reads two sources and writes one scratch register; the result ends in T1.
  function automatic uop_t crs_rom(input logic [PC_W-1:0] pc);
    uop_t u;
    case (pc)
      // Interior point: retardation of the old and trial values.
      6'd0:  u = mk(OP_MUL,  S_T0, S_AFF,  S_RP);
      6'd1:  u = mk(OP_ADDS, S_T0, S_T0,   S_ONE);
      6'd2:  u = mk(OP_MUL,  S_T0, S_T0,   S_T0);
      6'd3:  u = mk(OP_MUL,  S_T0, S_T0,   S_POR);
      6'd4:  u = mk(OP_ADDS, S_T0, S_T0,   S_EPS);
      6'd5:  u = mk(OP_SUB,  S_T1, S_ONE,  S_POR);
      6'd6:  u = mk(OP_MUL,  S_T1, S_T1,   S_CAP);
      6'd7:  u = mk(OP_MUL,  S_T1, S_T1,   S_AFF);
      6'd8:  u = mk(OP_DIV,  S_T2, S_T1,   S_T0);
      6'd9:  u = mk(OP_MUL,  S_T0, S_AFF,  S_RT);
      6'd10: u = mk(OP_ADDS, S_T0, S_T0,   S_ONE);
      6'd11: u = mk(OP_MUL,  S_T0, S_T0,   S_T0);
      6'd12: u = mk(OP_MUL,  S_T0, S_T0,   S_POR);
      6'd13: u = mk(OP_ADDS, S_T0, S_T0,   S_EPS);
      6'd14: u = mk(OP_DIV,  S_T3, S_T1,   S_T0);
      // Second and first differences.
      6'd15: u = mk(OP_MUL,  S_T0, S_RH,   S_RH);
      6'd16: u = mk(OP_ADD,  S_T4, S_OP,   S_CP);
      6'd17: u = mk(OP_SUB,  S_T4, S_T4,   S_RP);
      6'd18: u = mk(OP_SUB,  S_T4, S_T4,   S_RP);
      6'd19: u = mk(OP_DIV,  S_T4, S_T4,   S_T0);
      6'd20: u = mk(OP_ADD,  S_T5, S_OT,   S_CT);
      6'd21: u = mk(OP_SUB,  S_T5, S_T5,   S_RT);
      6'd22: u = mk(OP_SUB,  S_T5, S_T5,   S_RT);
      6'd23: u = mk(OP_DIV,  S_T5, S_T5,   S_T0);
      6'd24: u = mk(OP_ADD,  S_T0, S_RH,   S_RH);
      6'd25: u = mk(OP_SUB,  S_T6, S_CP,   S_OP);
      6'd26: u = mk(OP_DIV,  S_T6, S_T6,   S_T0);
      6'd27: u = mk(OP_SUB,  S_T7, S_CT,   S_OT);
      6'd28: u = mk(OP_DIV,  S_T7, S_T7,   S_T0);
      6'd29: u = mk(OP_SUB,  S_T0, S_RT,   S_RP);
      6'd30: u = mk(OP_DIV,  S_T0, S_T0,   S_TSTEP);
      // Dispersion and convection terms.
      6'd31: u = mk(OP_DIV,  S_T1, S_DISP, S_T2);
      6'd32: u = mk(OP_MUL,  S_T1, S_T1,   S_T4);
      6'd33: u = mk(OP_DIV,  S_T4, S_DISP, S_T3);
      6'd34: u = mk(OP_MUL,  S_T4, S_T4,   S_T5);
      6'd35: u = mk(OP_HALF, S_T1, S_T1,   S_T4);
      6'd36: u = mk(OP_DIV,  S_T4, S_VEL,  S_T2);
      6'd37: u = mk(OP_MUL,  S_T4, S_T4,   S_T6);
      6'd38: u = mk(OP_DIV,  S_T5, S_VEL,  S_T3);
      6'd39: u = mk(OP_MUL,  S_T5, S_T5,   S_T7);
      6'd40: u = mk(OP_HALF, S_T4, S_T4,   S_T5);
      6'd41: u = mk(OP_SUB,  S_T1, S_T1,   S_T4);
      6'd42: u = mk(OP_SUBS, S_T1, S_T1,   S_T0);
      6'd43: u = mk(OP_END,  S_T1, S_T1,   S_T1);
      // Inlet point.
      6'd44: u = mk(OP_SUB,  S_T0, S_CP,   S_RP);
      6'd45: u = mk(OP_DIV,  S_T0, S_T0,   S_RH);
      6'd46: u = mk(OP_SUB,  S_T1, S_CT,   S_RT);
      6'd47: u = mk(OP_DIV,  S_T1, S_T1,   S_RH);
      6'd48: u = mk(OP_HALF, S_T0, S_T0,   S_T1);
      6'd49: u = mk(OP_DIV,  S_T1, S_VEL,  S_DISP);
      6'd50: u = mk(OP_SUBS, S_T2, S_RT,   S_FEED);
      6'd51: u = mk(OP_MUL,  S_T1, S_T1,   S_T2);
      6'd52: u = mk(OP_SUBS, S_T1, S_T0,   S_T1);
      6'd53: u = mk(OP_END,  S_T1, S_T1,   S_T1);
      // Closing point, zero-gradient condition.
      6'd54: u = mk(OP_SUB,  S_T0, S_CP,   S_RP);
      6'd55: u = mk(OP_DIV,  S_T0, S_T0,   S_H);
      6'd56: u = mk(OP_SUB,  S_T1, S_CT,   S_RT);
      6'd57: u = mk(OP_DIV,  S_T1, S_T1,   S_H);
      6'd58: u = mk(OP_HALF, S_T1, S_T0,   S_T1);
      6'd59: u = mk(OP_ADDS, S_T1, S_T1,   S_ZERO);
      6'd60: u = mk(OP_END,  S_T1, S_T1,   S_T1);
      // Vector of a single point.
      6'd61: u = mk(OP_ADD,  S_T1, S_ZERO, S_ZERO);
      default: u = mk(OP_END, S_T1, S_T1, S_T1);
    endcase
    return u;
  endfunction

endpackage
`default_nettype wire

>>> sv/chromatography_residual_stencil.sv
// Top level of the chromatography residual stencil: configuration registers and the pipeline parts.
// Usage:
//   Grid points enter on the in channel (valid/ready), one transaction per point, with
//   end_of_grid_i set on the last point of a vector. Residuals leave on the out channel
//   (valid/ready), one point behind the input; the closing point of a vector yields two
//   transactions, the second with last_o set. A single-point vector gives one zero residual.
//   The front end takes a point and queues a job (two entries deep); it keeps
//   accepting while the back end works or while a result waits on the output register.
//   The back end runs a micro-program on one multiplier and one divider that produces one
//   quotient bit per cycle. When the receiver stalls, the finished result holds in the
//   output register, the back end waits, and the queue fills before in_ready_o drops.
//   Reset clears the window, the queue and the output register and loads the default
//   configuration. Configuration registers are written with cfg_we_i while the block is idle.
`default_nettype none
module chromatography_residual_stencil #(
  parameter int unsigned MAX_POINTS = crs_pkg::MAX_POINTS_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic signed [31:0] prev_level_i,
  input  logic signed [31:0] trial_level_i,
  input  logic [30:0]        spacing_i,
  input  logic               end_of_grid_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [31:0] residual_o,
  output logic [9:0]         point_index_o,
  output logic               last_o,
  input  logic               cfg_we_i,
  input  logic [2:0]         cfg_index_i,
  input  logic [31:0]        cfg_data_i
);
  import crs_pkg::*;

  cfg_t cfg_q;
  job_t job_in, job_head;
  logic push, pop, full, head_valid;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.velocity   <= 32'sd65536;
      cfg_q.dispersion <= 31'd65536;
      cfg_q.porosity   <= 16'd32768;
      cfg_q.capacity   <= 31'd65536;
      cfg_q.affinity   <= 31'd65536;
      cfg_q.time_step  <= 31'd65536;
      cfg_q.feed_level <= '0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        REG_VELOCITY:   cfg_q.velocity   <= $signed(cfg_data_i);
        REG_DISPERSION: cfg_q.dispersion <= cfg_data_i[30:0];
        REG_POROSITY:   cfg_q.porosity   <= cfg_data_i[15:0];
        REG_CAPACITY:   cfg_q.capacity   <= cfg_data_i[30:0];
        REG_AFFINITY:   cfg_q.affinity   <= cfg_data_i[30:0];
        REG_TIME_STEP:  cfg_q.time_step  <= cfg_data_i[30:0];
        REG_FEED_LEVEL: cfg_q.feed_level <= $signed(cfg_data_i);
        default: ;
      endcase
    end
  end

  crs_front #(.MAX_POINTS(MAX_POINTS)) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .prev_level_i  (prev_level_i),
    .trial_level_i (trial_level_i),
    .spacing_i     (spacing_i),
    .end_of_grid_i (end_of_grid_i),
    .full_i        (full),
    .push_o        (push),
    .job_o         (job_in)
  );

  crs_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .job_i   (job_in),
    .full_o  (full),
    .pop_i   (pop),
    .valid_o (head_valid),
    .job_o   (job_head)
  );

  crs_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg_q),
    .job_valid_i   (head_valid),
    .job_i         (job_head),
    .job_pop_o     (pop),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .residual_o    (residual_o),
    .point_index_o (point_index_o),
    .last_o        (last_o)
  );
endmodule
`default_nettype wire

>>> sv/crs_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module crs_ram #(
  parameter int unsigned WIDTH = 36,
  parameter int unsigned DEPTH = 8
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);
  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;
endmodule
`default_nettype wire

>>> sv/crs_front.sv
// Input side: keeps the three-point window and turns each point into a job.
`default_nettype none
module crs_front #(
  parameter int unsigned MAX_POINTS = crs_pkg::MAX_POINTS_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic signed [31:0] prev_level_i,
  input  logic signed [31:0] trial_level_i,
  input  logic [30:0]        spacing_i,
  input  logic               end_of_grid_i,
  input  logic               full_i,
  output logic               push_o,
  output crs_pkg::job_t      job_o
);
  import crs_pkg::*;

  localparam int unsigned CW = (MAX_POINTS > 2) ? $clog2(MAX_POINTS) : 1;

  logic [CW-1:0]      cnt_q;
  logic signed [31:0] older_prev_q, older_trial_q, recent_prev_q, recent_trial_q;
  logic [30:0]        recent_spacing_q;
  logic               accept, last_pt;
  logic [31:0]        cnt_ext;

  assign in_ready_o = !full_i;
  assign accept     = in_valid_i && !full_i;
  assign last_pt    = end_of_grid_i || (cnt_q == CW'(MAX_POINTS - 1));
  assign cnt_ext    = 32'(cnt_q);

  always_comb begin
    job_o.kind           = (cnt_q == '0) ? K_SINGLE :
                           (cnt_q == CW'(1)) ? K_INLET : K_INTERIOR;
    job_o.end_flag       = last_pt;
    job_o.cnt            = cnt_ext[9:0];
    job_o.older_prev     = older_prev_q;
    job_o.older_trial    = older_trial_q;
    job_o.recent_prev    = recent_prev_q;
    job_o.recent_trial   = recent_trial_q;
    job_o.recent_spacing = recent_spacing_q;
    job_o.cur_prev       = prev_level_i;
    job_o.cur_trial      = trial_level_i;
    job_o.cur_spacing    = spacing_i;
  end

  // The first point of a vector only fills the window unless it also ends it.
  assign push_o = accept && !((cnt_q == '0) && !last_pt);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q            <= '0;
      older_prev_q     <= '0;
      older_trial_q    <= '0;
      recent_prev_q    <= '0;
      recent_trial_q   <= '0;
      recent_spacing_q <= '0;
    end else if (accept) begin
      if (last_pt) begin
        cnt_q            <= '0;
        older_prev_q     <= '0;
        older_trial_q    <= '0;
        recent_prev_q    <= '0;
        recent_trial_q   <= '0;
        recent_spacing_q <= '0;
      end else begin
        cnt_q            <= cnt_q + CW'(1);
        older_prev_q     <= recent_prev_q;
        older_trial_q    <= recent_trial_q;
        recent_prev_q    <= prev_level_i;
        recent_trial_q   <= trial_level_i;
        recent_spacing_q <= spacing_i;
      end
    end
  end
endmodule
`default_nettype wire

>>> sv/crs_queue.sv
// Short job queue between the window front end and the arithmetic back end.
`default_nettype none
module crs_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  crs_pkg::job_t job_i,
  output logic          full_o,
  input  logic          pop_i,
  output logic          valid_o,
  output crs_pkg::job_t job_o
);
  import crs_pkg::*;

  localparam int unsigned PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned NW = $clog2(QUEUE_DEPTH + 1);

  job_t          slot_q [QUEUE_DEPTH];
  logic [PW-1:0] wr_q, rd_q;
  logic [NW-1:0] num_q;

  assign full_o  = (num_q == NW'(QUEUE_DEPTH));
  assign valid_o = (num_q != '0);
  assign job_o   = slot_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_q] <= job_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      num_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= (wr_q == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_q + PW'(1);
      end
      if (pop_i) begin
        rd_q <= (rd_q == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_q + PW'(1);
      end
      if (push_i && !pop_i) begin
        num_q <= num_q + NW'(1);
      end else if (pop_i && !push_i) begin
        num_q <= num_q - NW'(1);
      end
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !full_o) else $error("job pushed into a full queue");
  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> valid_o) else $error("job popped from an empty queue");
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    num_q <= NW'(QUEUE_DEPTH)) else $error("queue count out of range");
endmodule
`default_nettype wire

>>> sv/crs_back.sv
// Arithmetic back end: micro-programmed sequencer with shared multiplier and divider.
`default_nettype none
module crs_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  crs_pkg::cfg_t      cfg_i,
  input  logic               job_valid_i,
  input  crs_pkg::job_t      job_i,
  output logic               job_pop_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [31:0] residual_o,
  output logic [9:0]         point_index_o,
  output logic               last_o
);
  import crs_pkg::*;

  localparam int unsigned QW = 32;
  localparam int unsigned DW = $clog2(QW);
  localparam int unsigned AW = $clog2(TEMP_DEPTH);

  typedef enum logic [2:0] {
    B_IDLE,
    B_FETCH,
    B_EXEC,
    B_MUL,
    B_DIV,
    B_EMIT
  } state_e;

  state_e               state_q;
  logic [PC_W-1:0]      pc_q;
  logic                 phase_q;
  logic signed [63:0]   prod_q;
  logic [31:0]          rem_q, lo_q, quo_q, den_q;
  logic                 neg_q;
  logic [DW-1:0]        dcnt_q;
  logic                 out_valid_q, last_q;
  logic signed [31:0]   residual_q;
  logic [9:0]           index_q;

  uop_t                 uop;
  logic [DATA_W-1:0]    rd_a, rd_b;
  dat_t                 a_val, b_val, alu_res;
  logic signed [DATA_W:0] sum, diff, half_t;
  logic signed [31:0]   ma, mb, m_res, div_early, div_fin;
  logic signed [63:0]   m_adj;
  logic                 a_neg, den_zero, ovf, ram_we, can_emit, more, use_cnt, emit_go;
  logic [DATA_W-1:0]    a_mag;
  logic [31:0]          den;
  logic [32:0]          trial;
  logic                 ge;
  logic [31:0]          rem_next, quo_next;
  dat_t                 wdata;

  function automatic dat_t pick(input src_e s, input job_t j, input cfg_t c,
                                input logic [DATA_W-1:0] rd);
    dat_t v;
    case (s)
      S_ZERO:  v = '0;
      S_ONE:   v = DATA_W'(65536);
      S_EPS:   v = DATA_W'(1);
      S_VEL:   v = DATA_W'(c.velocity);
      S_DISP:  v = $signed(DATA_W'(c.dispersion));
      S_POR:   v = $signed(DATA_W'(c.porosity));
      S_CAP:   v = $signed(DATA_W'(c.capacity));
      S_AFF:   v = $signed(DATA_W'(c.affinity));
      S_TSTEP: v = $signed(DATA_W'(c.time_step));
      S_FEED:  v = DATA_W'(c.feed_level);
      S_OP:    v = DATA_W'(j.older_prev);
      S_OT:    v = DATA_W'(j.older_trial);
      S_RP:    v = DATA_W'(j.recent_prev);
      S_RT:    v = DATA_W'(j.recent_trial);
      S_RH:    v = $signed(DATA_W'(j.recent_spacing));
      S_CP:    v = DATA_W'(j.cur_prev);
      S_CT:    v = DATA_W'(j.cur_trial);
      S_H:     v = $signed(DATA_W'(j.cur_spacing));
      default: v = $signed(rd);
    endcase
    return v;
  endfunction

  // Apply the sign to an unsigned quotient magnitude and saturate.
  function automatic logic signed [31:0] fix_sign(input logic [31:0] q, input logic neg);
    logic signed [31:0] r;
    if (!neg) begin
      r = q[31] ? FX_MAX : $signed(q);
    end else begin
      r = (q > 32'h80000000) ? FX_MIN : $signed(-q);
    end
    return r;
  endfunction

  assign uop   = crs_rom(pc_q);
  assign a_val = pick(uop.a, job_i, cfg_i, rd_a);
  assign b_val = pick(uop.b, job_i, cfg_i, rd_b);

  crs_ram #(.WIDTH(DATA_W), .DEPTH(TEMP_DEPTH)) u_ram_a (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (uop.dst[AW-1:0]),
    .wdata_i (wdata),
    .raddr_i (uop.a[AW-1:0]),
    .rdata_o (rd_a)
  );

  crs_ram #(.WIDTH(DATA_W), .DEPTH(TEMP_DEPTH)) u_ram_b (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (uop.dst[AW-1:0]),
    .wdata_i (wdata),
    .raddr_i (uop.b[AW-1:0]),
    .rdata_o (rd_b)
  );

  always_comb begin
    sum    = (DATA_W+1)'(a_val) + (DATA_W+1)'(b_val);
    diff   = (DATA_W+1)'(a_val) - (DATA_W+1)'(b_val);
    half_t = (sum + $signed({{DATA_W{1'b0}}, sum[DATA_W]})) >>> 1;
    case (uop.op)
      OP_ADD:  alu_res = sum[DATA_W-1:0];
      OP_SUB:  alu_res = diff[DATA_W-1:0];
      OP_ADDS: alu_res = DATA_W'(sat32(64'(sum)));
      OP_SUBS: alu_res = DATA_W'(sat32(64'(diff)));
      OP_HALF: alu_res = half_t[DATA_W-1:0];
      default: alu_res = '0;
    endcase
  end

  // Multiplier operands are saturated; the product is scaled with truncation toward zero.
  assign ma    = sat32(64'(a_val));
  assign mb    = sat32(64'(b_val));
  assign m_adj = prod_q + $signed({48'b0, {16{prod_q[63]}}});
  assign m_res = sat32(m_adj >>> 16);

  // Denominators are never negative, so the divider works on magnitudes.
  assign a_neg    = a_val[DATA_W-1];
  assign a_mag    = a_neg ? DATA_W'(-a_val) : DATA_W'(a_val);
  assign den      = b_val[31:0];
  assign den_zero = (den == '0);
  assign ovf      = (32'(a_mag[DATA_W-1:16]) >= den);

  always_comb begin
    if (den_zero) begin
      div_early = a_neg ? FX_MIN : ((a_val != '0) ? FX_MAX : '0);
    end else begin
      div_early = a_neg ? FX_MIN : FX_MAX;
    end
  end

  assign trial    = {rem_q, lo_q[31]};
  assign ge       = (trial >= {1'b0, den_q});
  assign rem_next = ge ? 32'(trial - {1'b0, den_q}) : trial[31:0];
  assign quo_next = {quo_q[30:0], ge};
  assign div_fin  = fix_sign(quo_next, neg_q);

  always_comb begin
    ram_we = 1'b0;
    wdata  = alu_res;
    case (state_q)
      B_EXEC: begin
        if (uop.op == OP_DIV) begin
          ram_we = den_zero || ovf;
          wdata  = DATA_W'(div_early);
        end else if (uop.op != OP_MUL && uop.op != OP_END) begin
          ram_we = 1'b1;
        end
      end
      B_MUL: begin
        ram_we = 1'b1;
        wdata  = DATA_W'(m_res);
      end
      B_DIV: begin
        ram_we = (dcnt_q == DW'(QW - 1));
        wdata  = DATA_W'(div_fin);
      end
      default: ram_we = 1'b0;
    endcase
  end

  assign can_emit  = !out_valid_q || out_ready_i;
  assign emit_go   = (state_q == B_EMIT) && can_emit;
  assign more      = !phase_q && job_i.end_flag && (job_i.kind != K_SINGLE);
  assign use_cnt   = phase_q || (job_i.kind == K_SINGLE);
  assign job_pop_o = emit_go && !more;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= B_IDLE;
      pc_q        <= '0;
      phase_q     <= 1'b0;
      out_valid_q <= 1'b0;
      prod_q      <= '0;
      rem_q       <= '0;
      lo_q        <= '0;
      quo_q       <= '0;
      den_q       <= '0;
      neg_q       <= 1'b0;
      dcnt_q      <= '0;
      residual_q  <= '0;
      index_q     <= '0;
      last_q      <= 1'b0;
    end else begin
      if (emit_go) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        B_IDLE: begin
          if (job_valid_i) begin
            pc_q    <= entry_pc(job_i.kind);
            phase_q <= 1'b0;
            state_q <= B_FETCH;
          end
        end
        B_FETCH: begin
          state_q <= (uop.op == OP_END) ? B_EMIT : B_EXEC;
        end
        B_EXEC: begin
          case (uop.op)
            OP_MUL: begin
              prod_q  <= 64'(ma) * 64'(mb);
              state_q <= B_MUL;
            end
            OP_DIV: begin
              if (den_zero || ovf) begin
                pc_q    <= pc_q + 1'b1;
                state_q <= B_FETCH;
              end else begin
                rem_q   <= 32'(a_mag[DATA_W-1:16]);
                lo_q    <= {a_mag[15:0], 16'h0};
                quo_q   <= '0;
                den_q   <= den;
                neg_q   <= a_neg;
                dcnt_q  <= '0;
                state_q <= B_DIV;
              end
            end
            default: begin
              pc_q    <= pc_q + 1'b1;
              state_q <= B_FETCH;
            end
          endcase
        end
        B_MUL: begin
          pc_q    <= pc_q + 1'b1;
          state_q <= B_FETCH;
        end
        B_DIV: begin
          rem_q  <= rem_next;
          lo_q   <= {lo_q[30:0], 1'b0};
          quo_q  <= quo_next;
          dcnt_q <= dcnt_q + DW'(1);
          if (dcnt_q == DW'(QW - 1)) begin
            pc_q    <= pc_q + 1'b1;
            state_q <= B_FETCH;
          end
        end
        B_EMIT: begin
          if (can_emit) begin
            residual_q  <= rd_a[31:0];
            index_q     <= use_cnt ? job_i.cnt : job_i.cnt - 10'd1;
            last_q      <= use_cnt;
            if (more) begin
              phase_q <= 1'b1;
              pc_q    <= P_LAST;
              state_q <= B_FETCH;
            end else begin
              state_q <= B_IDLE;
            end
          end
        end
        default: state_q <= B_IDLE;
      endcase
    end
  end

  assign out_valid_o   = out_valid_q;
  assign residual_o    = residual_q;
  assign point_index_o = index_q;
  assign last_o        = last_q;

  a_div_den: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == B_DIV) |-> (den_q != '0)) else $error("divider running on zero");
  a_pop_job: assert property (@(posedge clk_i) disable iff (!rst_ni)
    job_pop_o |-> job_valid_i) else $error("finished a job that was not queued");
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_ready_i) |=> (out_valid_q && $stable(residual_q)
                                       && $stable(index_q) && $stable(last_q)))
    else $error("output transaction changed while stalled");
endmodule
`default_nettype wire
